// ===== hdl/sd_card_spi_init_sequencer_macros.svh =====
// assertion helpers for the sd card spi start-up sequencer
`ifndef SD_CARD_SPI_INIT_SEQUENCER_MACROS_SVH
`define SD_CARD_SPI_INIT_SEQUENCER_MACROS_SVH

// same-cycle implication
`define SDSPI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sdspi assertion failed");

// next-cycle implication
`define SDSPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sdspi assertion failed");

`endif

// ===== hdl/sdspi_pkg.sv =====
package sdspi_pkg;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_CMD0     = 3'd1;
	localparam logic [2:0] PH_CMD8     = 3'd2;
	localparam logic [2:0] PH_V1PROBE  = 3'd3;
	localparam logic [2:0] PH_V2ACMD41 = 3'd4;
	localparam logic [2:0] PH_V1ACMD41 = 3'd5;
	localparam logic [2:0] PH_CMD58    = 3'd6;
	localparam logic [2:0] PH_CMD16    = 3'd7;

	localparam logic [1:0] ACT_SEND = 2'd0;
	localparam logic [1:0] ACT_OK   = 2'd1;
	localparam logic [1:0] ACT_FAIL = 2'd2;

	localparam logic       KIND_START    = 1'b0;
	localparam logic       KIND_RESPONSE = 1'b1;

	localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
	localparam logic [5:0] CMD_SEND_IF   = 6'd8;
	localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
	localparam logic [5:0] CMD_OP_COND   = 6'd41;
	localparam logic [5:0] CMD_READ_OCR  = 6'd58;

	localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
	localparam logic [31:0] ARG_BLOCKLEN = 32'd512;
	localparam logic [7:0]  R1_IDLE      = 8'h01;
	localparam logic [7:0]  R1_READY     = 8'h00;
	localparam logic [7:0]  VHS_27_36    = 8'h01;
	localparam logic [7:0]  CHECK_PAT    = 8'hAA;

	localparam logic [7:0]  PREAMBLE_BYTES = 8'd10;
	localparam logic [2:0]  R7_BYTES       = 3'd4;
	localparam logic [15:0] RETRY_RESET    = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  action;
		logic [5:0]  cmd_index;
		logic        app_cmd;
		logic [31:0] cmd_arg;
		logic [7:0]  preamble_bytes;
		logic [2:0]  trailing_bytes;
	} result_t;

	typedef struct packed {
		logic        emit;
		logic [2:0]  phase;
		logic [15:0] retries;
		result_t     res;
	} step_t;

endpackage

// ===== hdl/sdspi_ifs.sv =====
interface sdspi_rsp_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  resp_r1;
	logic [31:0] resp_trailing;

	modport source (output valid, kind, resp_r1, resp_trailing, input ready);
	modport sink (input valid, kind, resp_r1, resp_trailing, output ready);
endinterface

interface sdspi_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [5:0]  cmd_index;
	logic        app_cmd;
	logic [31:0] cmd_arg;
	logic [7:0]  preamble_bytes;
	logic [2:0]  trailing_bytes;

	modport source (output valid, action, cmd_index, app_cmd, cmd_arg, preamble_bytes,
		trailing_bytes, input ready);
	modport sink (input valid, action, cmd_index, app_cmd, cmd_arg, preamble_bytes,
		trailing_bytes, output ready);
endinterface

// ===== hdl/sdspi_step.sv =====
module sdspi_step (
	input  logic                kind,
	input  logic [7:0]          resp_r1,
	input  logic [31:0]         resp_trailing,
	input  logic [2:0]          phase,
	input  logic [15:0]         retries,
	input  logic [15:0]         retry_limit,
	output sdspi_pkg::step_t    step
);

	sdspi_pkg::result_t r_send_cmd0;
	sdspi_pkg::result_t r_send_cmd8;
	sdspi_pkg::result_t r_send_acmd41;
	sdspi_pkg::result_t r_send_cmd58;
	sdspi_pkg::result_t r_send_cmd16;
	sdspi_pkg::result_t r_ok;
	sdspi_pkg::result_t r_fail;
	logic               can_retry;
	logic               limit_zero;
	logic               r7_ok;

	always_comb begin
		r_send_cmd0 = '{sdspi_pkg::ACT_SEND, sdspi_pkg::CMD_GO_IDLE, 1'b0, 32'd0,
			sdspi_pkg::PREAMBLE_BYTES, 3'd0};
		r_send_cmd8 = '{sdspi_pkg::ACT_SEND, sdspi_pkg::CMD_SEND_IF, 1'b0,
			sdspi_pkg::ARG_IF_COND, 8'd0, sdspi_pkg::R7_BYTES};
		r_send_acmd41 = '{sdspi_pkg::ACT_SEND, sdspi_pkg::CMD_OP_COND, 1'b1, 32'd0, 8'd0, 3'd0};
		r_send_cmd58 = '{sdspi_pkg::ACT_SEND, sdspi_pkg::CMD_READ_OCR, 1'b0, 32'd0, 8'd0,
			sdspi_pkg::R7_BYTES};
		r_send_cmd16 = '{sdspi_pkg::ACT_SEND, sdspi_pkg::CMD_BLOCKLEN, 1'b0,
			sdspi_pkg::ARG_BLOCKLEN, 8'd0, 3'd0};
		r_ok   = '{sdspi_pkg::ACT_OK, 6'd0, 1'b0, 32'd0, 8'd0, 3'd0};
		r_fail = '{sdspi_pkg::ACT_FAIL, 6'd0, 1'b0, 32'd0, 8'd0, 3'd0};
	end

	assign can_retry  = (retries > 16'd1);
	assign limit_zero = (retry_limit == 16'd0);
	assign r7_ok      = (resp_trailing[15:8] == sdspi_pkg::VHS_27_36) &&
		(resp_trailing[7:0] == sdspi_pkg::CHECK_PAT);

	always_comb begin
		step.emit    = 1'b1;
		step.phase   = phase;
		step.retries = retries;
		step.res     = r_fail;
		if (kind == sdspi_pkg::KIND_START) begin
			step.retries = 16'd0;
			step.phase   = sdspi_pkg::PH_CMD0;
			step.res     = r_send_cmd0;
		end else begin
			case (phase)
				sdspi_pkg::PH_CMD0: begin
					if (resp_r1 == sdspi_pkg::R1_IDLE) begin
						step.phase = sdspi_pkg::PH_CMD8;
						step.res   = r_send_cmd8;
					end else begin
						step.phase = sdspi_pkg::PH_IDLE;
					end
				end
				sdspi_pkg::PH_CMD8: begin
					if (resp_r1 == sdspi_pkg::R1_IDLE) begin
						step.retries = retry_limit;
						if (r7_ok && !limit_zero) begin
							step.phase = sdspi_pkg::PH_V2ACMD41;
							step.res   = r_send_acmd41;
						end else begin
							step.phase = sdspi_pkg::PH_IDLE;
						end
						if (!r7_ok) begin
							step.retries = retries;
						end
					end else begin
						step.phase = sdspi_pkg::PH_V1PROBE;
						step.res   = r_send_acmd41;
					end
				end
				sdspi_pkg::PH_V1PROBE: begin
					if (resp_r1 <= sdspi_pkg::R1_IDLE) begin
						step.retries = retry_limit;
						if (!limit_zero) begin
							step.phase = sdspi_pkg::PH_V1ACMD41;
							step.res   = r_send_acmd41;
						end else begin
							step.phase = sdspi_pkg::PH_IDLE;
						end
					end else begin
						step.phase = sdspi_pkg::PH_IDLE;
					end
				end
				sdspi_pkg::PH_V2ACMD41, sdspi_pkg::PH_V1ACMD41: begin
					if (resp_r1 == sdspi_pkg::R1_READY) begin
						if (phase == sdspi_pkg::PH_V2ACMD41) begin
							step.phase = sdspi_pkg::PH_CMD58;
							step.res   = r_send_cmd58;
						end else begin
							step.phase = sdspi_pkg::PH_CMD16;
							step.res   = r_send_cmd16;
						end
					end else if (can_retry) begin
						step.retries = retries - 16'd1;
						step.res     = r_send_acmd41;
					end else begin
						step.retries = 16'd0;
						step.phase   = sdspi_pkg::PH_IDLE;
					end
				end
				sdspi_pkg::PH_CMD58: begin
					if (resp_r1 == sdspi_pkg::R1_READY) begin
						step.phase = sdspi_pkg::PH_CMD16;
						step.res   = r_send_cmd16;
					end else if (can_retry) begin
						step.retries = retries - 16'd1;
						step.res     = r_send_cmd58;
					end else begin
						step.retries = 16'd0;
						step.phase   = sdspi_pkg::PH_IDLE;
					end
				end
				sdspi_pkg::PH_CMD16: begin
					step.phase = sdspi_pkg::PH_IDLE;
					step.res   = r_ok;
				end
				default: begin
					// response with nothing outstanding is dropped
					step.emit = 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== hdl/sd_card_spi_init_sequencer.sv =====
// SD card SPI-mode start-up sequencer. A start transaction (kind 0) on rsp begins or restarts
// the sequence and yields CMD0 with the dummy-byte preamble; each response transaction
// (kind 1) carries the R1 byte and trailing R7/R3 bytes of the last command and yields
// exactly one cmd transaction naming the next command or reporting success or failure.
// A response while no command is outstanding is dropped. retry_limit (write cfg_we with
// cfg_wdata while idle) bounds the shared ACMD41/CMD58 polling. An accepted rsp passes through
// one input register, one decision step and one result register before cmd valid.
// One transaction is accepted every cycle while cmd is taken each cycle; the input
// register holds one extra transaction while the cmd side stalls.
`include "sd_card_spi_init_sequencer_macros.svh"

module sd_card_spi_init_sequencer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	sdspi_rsp_if.sink    rsp,
	sdspi_cmd_if.source  cmd
);

	logic                valid_s1;
	logic                kind_s1;
	logic [7:0]          r1_s1;
	logic [31:0]         tr_s1;
	logic [15:0]         retry_limit_q;
	logic [2:0]          phase_q;
	logic [15:0]         retries_q;
	logic                out_valid_q;
	sdspi_pkg::result_t  res_q;
	sdspi_pkg::step_t    step;
	logic                out_free;
	logic                adv_s1;

	assign out_free  = !out_valid_q || cmd.ready;
	assign adv_s1    = valid_s1 && out_free;
	assign rsp.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= sdspi_pkg::RETRY_RESET;
		end else if (cfg_we) begin
			retry_limit_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rsp.ready) begin
			valid_s1 <= rsp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.ready && rsp.valid) begin
			kind_s1 <= rsp.kind;
			r1_s1   <= rsp.resp_r1;
			tr_s1   <= rsp.resp_trailing;
		end
	end

	sdspi_step u_step (
		.kind          (kind_s1),
		.resp_r1       (r1_s1),
		.resp_trailing (tr_s1),
		.phase         (phase_q),
		.retries       (retries_q),
		.retry_limit   (retry_limit_q),
		.step          (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sdspi_pkg::PH_IDLE;
			retries_q   <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				phase_q   <= step.phase;
				retries_q <= step.retries;
			end
			if (out_free) begin
				out_valid_q <= adv_s1 && step.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && step.emit) begin
			res_q <= step.res;
		end
	end

	assign cmd.valid          = out_valid_q;
	assign cmd.action         = res_q.action;
	assign cmd.cmd_index      = res_q.cmd_index;
	assign cmd.app_cmd        = res_q.app_cmd;
	assign cmd.cmd_arg        = res_q.cmd_arg;
	assign cmd.preamble_bytes = res_q.preamble_bytes;
	assign cmd.trailing_bytes = res_q.trailing_bytes;

	`SDSPI_ASSERT_NEXT(a_finish_idle, clk, arst_n,
		adv_s1 && step.emit && (step.res.action != sdspi_pkg::ACT_SEND),
		phase_q == sdspi_pkg::PH_IDLE)
	`SDSPI_ASSERT_NOW(a_poll_budget, clk, arst_n,
		(phase_q == sdspi_pkg::PH_V2ACMD41) || (phase_q == sdspi_pkg::PH_V1ACMD41) ||
		(phase_q == sdspi_pkg::PH_CMD58), retries_q != 16'd0)
	`SDSPI_ASSERT_NOW(a_done_fields_zero, clk, arst_n,
		cmd.valid && (cmd.action != sdspi_pkg::ACT_SEND),
		(cmd.cmd_index == 6'd0) && (cmd.cmd_arg == 32'd0) && !cmd.app_cmd &&
		(cmd.preamble_bytes == 8'd0) && (cmd.trailing_bytes == 3'd0))
	`SDSPI_ASSERT_NOW(a_stall_only_full, clk, arst_n, !rsp.ready, valid_s1 && out_valid_q)

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

class init_flow_tracker;
	logic [15:0]          retry_limit;
	logic [2:0]           phase;
	logic [15:0]          retries_left;
	sdspi_pkg::result_t   cmd_expected[$];
	int                   errors;
	int                   checked;

	function new();
		retry_limit  = sdspi_pkg::RETRY_RESET;
		phase        = sdspi_pkg::PH_IDLE;
		retries_left = '0;
		errors       = 0;
		checked      = 0;
	endfunction

	function void report(string msg);
		$display("ERROR: %s", msg);
		errors++;
	endfunction

	function sdspi_pkg::result_t send_cmd(logic [5:0] idx, logic app, logic [31:0] arg,
		logic [2:0] trail);
		sdspi_pkg::result_t r;
		r = '0;
		r.action         = sdspi_pkg::ACT_SEND;
		r.cmd_index      = idx;
		r.app_cmd        = app;
		r.cmd_arg        = arg;
		r.trailing_bytes = trail;
		return r;
	endfunction

	function sdspi_pkg::result_t finish_init(logic [1:0] act);
		sdspi_pkg::result_t r;
		r = '0;
		r.action = act;
		phase    = sdspi_pkg::PH_IDLE;
		return r;
	endfunction

	function sdspi_pkg::result_t begin_polling(logic [2:0] next_phase);
		retries_left = retry_limit;
		if (retries_left == 0)
			return finish_init(sdspi_pkg::ACT_FAIL);
		phase = next_phase;
		return send_cmd(sdspi_pkg::CMD_OP_COND, 1'b1, '0, '0);
	endfunction

	function bit spend_retry();
		if (retries_left <= 1) begin
			retries_left = '0;
			return 1'b0;
		end
		retries_left--;
		return 1'b1;
	endfunction

	// predicts the command for one accepted rsp transaction
	function void note_response(logic kind, logic [7:0] r1, logic [31:0] tr);
		sdspi_pkg::result_t r;
		bit                 has_result;
		has_result = 1'b1;
		r = '0;
		if (kind == sdspi_pkg::KIND_START) begin
			retries_left = '0;
			phase = sdspi_pkg::PH_CMD0;
			r = send_cmd(sdspi_pkg::CMD_GO_IDLE, 1'b0, '0, '0);
			r.preamble_bytes = sdspi_pkg::PREAMBLE_BYTES;
		end else begin
			case (phase)
				sdspi_pkg::PH_CMD0: begin
					if (r1 == sdspi_pkg::R1_IDLE) begin
						phase = sdspi_pkg::PH_CMD8;
						r = send_cmd(sdspi_pkg::CMD_SEND_IF, 1'b0, sdspi_pkg::ARG_IF_COND,
							sdspi_pkg::R7_BYTES);
					end else
						r = finish_init(sdspi_pkg::ACT_FAIL);
				end
				sdspi_pkg::PH_CMD8: begin
					if (r1 == sdspi_pkg::R1_IDLE) begin
						if (tr[15:8] == sdspi_pkg::VHS_27_36 && tr[7:0] == sdspi_pkg::CHECK_PAT)
							r = begin_polling(sdspi_pkg::PH_V2ACMD41);
						else
							r = finish_init(sdspi_pkg::ACT_FAIL);
					end else begin
						phase = sdspi_pkg::PH_V1PROBE;
						r = send_cmd(sdspi_pkg::CMD_OP_COND, 1'b1, '0, '0);
					end
				end
				sdspi_pkg::PH_V1PROBE: begin
					if (r1 <= sdspi_pkg::R1_IDLE)
						r = begin_polling(sdspi_pkg::PH_V1ACMD41);
					else
						r = finish_init(sdspi_pkg::ACT_FAIL);
				end
				sdspi_pkg::PH_V2ACMD41, sdspi_pkg::PH_V1ACMD41: begin
					if (r1 == sdspi_pkg::R1_READY) begin
						if (phase == sdspi_pkg::PH_V2ACMD41) begin
							phase = sdspi_pkg::PH_CMD58;
							r = send_cmd(sdspi_pkg::CMD_READ_OCR, 1'b0, '0, sdspi_pkg::R7_BYTES);
						end else begin
							phase = sdspi_pkg::PH_CMD16;
							r = send_cmd(sdspi_pkg::CMD_BLOCKLEN, 1'b0, sdspi_pkg::ARG_BLOCKLEN,
								'0);
						end
					end else if (spend_retry())
						r = send_cmd(sdspi_pkg::CMD_OP_COND, 1'b1, '0, '0);
					else
						r = finish_init(sdspi_pkg::ACT_FAIL);
				end
				sdspi_pkg::PH_CMD58: begin
					if (r1 == sdspi_pkg::R1_READY) begin
						phase = sdspi_pkg::PH_CMD16;
						r = send_cmd(sdspi_pkg::CMD_BLOCKLEN, 1'b0, sdspi_pkg::ARG_BLOCKLEN, '0);
					end else if (spend_retry())
						r = send_cmd(sdspi_pkg::CMD_READ_OCR, 1'b0, '0, sdspi_pkg::R7_BYTES);
					else
						r = finish_init(sdspi_pkg::ACT_FAIL);
				end
				sdspi_pkg::PH_CMD16: r = finish_init(sdspi_pkg::ACT_OK);
				default: has_result = 1'b0;
			endcase
		end
		if (has_result)
			cmd_expected.push_back(r);
	endfunction

	function void check_command(sdspi_pkg::result_t got);
		sdspi_pkg::result_t want;
		string              diff;
		if (cmd_expected.size() == 0) begin
			report($sformatf("unexpected command transaction %p", got));
			return;
		end
		want = cmd_expected.pop_front();
		diff = "";
		if (got.action !== want.action)                 diff = {diff, " action"};
		if (got.cmd_index !== want.cmd_index)           diff = {diff, " cmd_index"};
		if (got.app_cmd !== want.app_cmd)               diff = {diff, " app_cmd"};
		if (got.cmd_arg !== want.cmd_arg)               diff = {diff, " cmd_arg"};
		if (got.preamble_bytes !== want.preamble_bytes) diff = {diff, " preamble_bytes"};
		if (got.trailing_bytes !== want.trailing_bytes) diff = {diff, " trailing_bytes"};
		if (diff != "")
			report($sformatf("command %0d mismatch in%s: got %p expected %p",
				checked, diff, got, want));
		checked++;
	endfunction
endclass

module tb;
	localparam int QUIET_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 190;
	localparam int LATENCY_WAIT  = 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	sdspi_rsp_if rsp_if();
	sdspi_cmd_if cmd_if();

	init_flow_tracker sb;

	int src_idle_pct;
	int snk_stall_pct;
	int hold_seq;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	sd_card_spi_init_sequencer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.rsp      (rsp_if),
		.cmd      (cmd_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// sink side: random stalls plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			cmd_if.ready <= 1'b0;
		end else
			cmd_if.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && cmd_if.valid && cmd_if.ready)
			sb.check_command({cmd_if.action, cmd_if.cmd_index, cmd_if.app_cmd, cmd_if.cmd_arg,
				cmd_if.preamble_bytes, cmd_if.trailing_bytes});
	end

	always @(posedge clk) begin
		if ((rsp_if.valid && rsp_if.ready) || (cmd_if.valid && cmd_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
			$display("FAIL sd_card_spi_init_sequencer");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic kind, input logic [7:0] r1, input logic [31:0] tr);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			rsp_if.valid <= 1'b0;
			@(negedge clk);
		end
		rsp_if.valid         <= 1'b1;
		rsp_if.kind          <= kind;
		rsp_if.resp_r1       <= r1;
		rsp_if.resp_trailing <= tr;
		do @(posedge clk); while (!rsp_if.ready);
		sb.note_response(kind, r1, tr);
		@(negedge clk);
	endtask

	task automatic drain();
		rsp_if.valid <= 1'b0;
		do @(negedge clk); while (sb.cmd_expected.size() != 0);
	endtask

	task automatic set_limit(input logic [15:0] value);
		drain();
		repeat (LATENCY_WAIT) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.retry_limit = value;
	endtask

	// mostly well-formed card answers for the current step, some noise and restarts
	task automatic pick_item(output logic kind, output logic [7:0] r1, output logic [31:0] tr);
		int roll;
		roll = $urandom_range(99);
		kind = sdspi_pkg::KIND_RESPONSE;
		r1   = 8'($urandom);
		tr   = $urandom;
		if (sb.phase == sdspi_pkg::PH_IDLE)
			kind = (roll < 8) ? sdspi_pkg::KIND_RESPONSE : sdspi_pkg::KIND_START;
		else if (roll < 3)
			kind = sdspi_pkg::KIND_START;
		else if (roll < 88) begin
			case (sb.phase)
				sdspi_pkg::PH_CMD0: r1 = sdspi_pkg::R1_IDLE;
				sdspi_pkg::PH_CMD8: begin
					if (roll < 55) begin
						r1 = sdspi_pkg::R1_IDLE;
						tr[15:0] = {sdspi_pkg::VHS_27_36, sdspi_pkg::CHECK_PAT};
					end else if (roll < 65)
						r1 = sdspi_pkg::R1_IDLE;
					else
						r1 = 8'h05;
				end
				sdspi_pkg::PH_V1PROBE:
					r1 = $urandom_range(1) ? sdspi_pkg::R1_IDLE : sdspi_pkg::R1_READY;
				sdspi_pkg::PH_V2ACMD41, sdspi_pkg::PH_V1ACMD41, sdspi_pkg::PH_CMD58:
					r1 = (roll < 30) ? sdspi_pkg::R1_READY : sdspi_pkg::R1_IDLE;
				default: ;
			endcase
		end
	endtask

	task automatic run_random(input int count, input bit hold_mid, input bit pause_mid);
		int       sent;
		bit       mid_done;
		logic     kind;
		logic [7:0]  r1;
		logic [31:0] tr;
		sent = 0;
		mid_done = 1'b0;
		while (sent < count) begin
			if (!mid_done && sent == count / 2) begin
				mid_done = 1'b1;
				if (hold_mid)
					hold_seq++;
				if (pause_mid)
					drain();
			end
			pick_item(kind, r1, tr);
			if (!(kind == sdspi_pkg::KIND_RESPONSE && sb.phase == sdspi_pkg::PH_IDLE))
				sent++;
			send_item(kind, r1, tr);
		end
	endtask

	task automatic run_directed();
		// version 2 card with retries on both polling loops
		send_item(sdspi_pkg::KIND_START, 8'h00, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'h0000_01AA);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_READY, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'hFFFF_FFFF);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_READY, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, 8'hFF, 32'hFFFF_FFFF);
		// response while idle is dropped
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_READY, 32'h1234_5678);
		// cmd0 not answered with idle
		send_item(sdspi_pkg::KIND_START, 8'hFF, 32'hFFFF_FFFF);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_READY, 32'h0);
		// version 1 card
		send_item(sdspi_pkg::KIND_START, 8'h00, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, 8'h05, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_READY, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_READY, 32'h0);
		// bad check pattern
		send_item(sdspi_pkg::KIND_START, 8'h00, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'hFFFF_01AB);
		// restarts while busy, then cmd0 fails
		send_item(sdspi_pkg::KIND_START, 8'h00, 32'h0);
		send_item(sdspi_pkg::KIND_START, 8'h00, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'hFFFF_01AA);
		send_item(sdspi_pkg::KIND_START, 8'h00, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, 8'hFF, 32'h0);
		// probe rejected
		send_item(sdspi_pkg::KIND_START, 8'h00, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, 8'h05, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, 8'h02, 32'h0);
		// polling exhausted on the last attempt
		set_limit(16'd1);
		send_item(sdspi_pkg::KIND_START, 8'h00, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'h0000_01AA);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'h0);
		// zero budget fails at once
		set_limit(16'd0);
		send_item(sdspi_pkg::KIND_START, 8'h00, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'h0);
		send_item(sdspi_pkg::KIND_RESPONSE, sdspi_pkg::R1_IDLE, 32'h0000_01AA);
	endtask

	initial begin
		logic [15:0] limit_plan [8];
		int          src_plan [4];
		int          snk_plan [4];
		sb = new();
		limit_plan = '{16'hFFFF, 16'd1, 16'd2, 16'd0, 16'd3, 16'hFFFF, 16'd9, 16'd1};
		src_plan   = '{0, 66, 0, 31};
		snk_plan   = '{0, 0, 66, 31};
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		hold_seq      = 0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		rsp_if.valid  = 1'b0;
		rsp_if.kind   = sdspi_pkg::KIND_START;
		rsp_if.resp_r1       = '0;
		rsp_if.resp_trailing = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 6)
				set_limit(16'($urandom_range(4, 40)));
			else
				set_limit(limit_plan[ph]);
			src_idle_pct  = src_plan[ph % 4];
			snk_stall_pct = snk_plan[ph % 4];
			run_random(PHASE_ITEMS, ph == 4, ph == 1);
		end
		drain();
		repeat (20) @(posedge clk);
		if (sb.cmd_expected.size() != 0)
			sb.report($sformatf("%0d commands never arrived", sb.cmd_expected.size()));
		if (sb.errors == 0)
			$display("PASS sd_card_spi_init_sequencer");
		else
			$display("FAIL sd_card_spi_init_sequencer");
		$finish;
	end
endmodule
